[rtl/ppoe_pkg.sv]
// shared types, constants and helpers of the parallel port output engine
package ppoe_pkg;

    localparam int QUEUE_DEPTH = 512;
    localparam int CMD_DEPTH   = 2;

    localparam int DATA_W     = 8;
    localparam int LINES_W    = 3;
    localparam int LEVEL_W    = 10;
    localparam int HOLD_W     = 16;
    localparam int TIMER_W    = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [LINES_W-1:0] LINE_SEL = 3'h4;

    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_ENABLE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_MASK      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_WATER        = 3'd4;

    localparam logic               RST_OUTPUT_ENABLE     = 1'b0;
    localparam logic [LINES_W-1:0] RST_CONTROL_MASK      = 3'd7;
    localparam logic [HOLD_W-1:0]  RST_HOLD_TICKS        = 16'd100;
    localparam logic [TIMER_W-1:0] RST_ACK_TIMEOUT_TICKS = 20'd6000;
    localparam logic [LEVEL_W-1:0] RST_HIGH_WATER        = 10'd400;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_ACK   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_HOLD = 2'd1,
        MODE_ACK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        WS_OK     = 2'd0,
        WS_NOT_EN = 2'd1,
        WS_ERROR  = 2'd2,
        WS_FULL   = 2'd3
    } t_wstat;

    typedef struct packed {
        logic               output_enable;
        logic [LINES_W-1:0] control_mask;
        logic [HOLD_W-1:0]  hold_ticks;
        logic [TIMER_W-1:0] ack_timeout_ticks;
        logic [LEVEL_W-1:0] high_water;
    } t_cfg;

    typedef struct packed {
        t_req              req;
        logic [DATA_W-1:0] data_byte;
        logic              fault;
    } t_cmd;

    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        logic               data_strobe;
        logic               send_pending;
        logic               stopped;
        logic               error_flag;
        logic [LEVEL_W-1:0] queue_level;
        logic               writable;
        t_wstat             write_status;
    } t_result;

    function automatic logic line_fault(input logic [LINES_W-1:0] lines,
                                        input logic [LINES_W-1:0] mask);
        return ((lines ^ LINE_SEL) & mask) != '0;
    endfunction

endpackage

[rtl/ppoe_in_if.sv]
// input channel interface: request type, data byte and sampled status lines
interface ppoe_in_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         req_type;
    logic [ppoe_pkg::DATA_W-1:0]        data_byte;
    logic [ppoe_pkg::LINES_W-1:0]       status_lines;

    modport source (output valid, req_type, data_byte, status_lines, input ready);
    modport sink   (input valid, req_type, data_byte, status_lines, output ready);
endinterface

[rtl/ppoe_out_if.sv]
// result channel interface: port data, strobe and status flags
interface ppoe_out_if;
    logic                               valid;
    logic                               ready;
    logic [ppoe_pkg::DATA_W-1:0]        data_out;
    logic                               data_strobe;
    logic                               send_pending;
    logic                               stopped;
    logic                               error_flag;
    logic [ppoe_pkg::LEVEL_W-1:0]       queue_level;
    logic                               writable;
    logic [1:0]                         write_status;

    modport source (output valid, data_out, data_strobe, send_pending, stopped, error_flag,
                    queue_level, writable, write_status, input ready);
    modport sink   (input valid, data_out, data_strobe, send_pending, stopped, error_flag,
                    queue_level, writable, write_status, output ready);
endinterface

[rtl/parallel_port_output_engine_top.sv]
// top level of the parallel port output engine: configuration registers and block wiring
// an accepted input transaction is written into the command queue; the result register loads when the back end pops it
// throughput: one transaction per cycle while the result side does not stall, set by the command step of the back end
// a two-entry command queue lets input and result sides stall independently
// reset: synchronous, active low; the byte queue needs no clearing pass, so input is taken
// from the first cycle after reset
module parallel_port_output_engine_top #(
    parameter int QUEUE_DEPTH = ppoe_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ppoe_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [ppoe_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    ppoe_in_if.sink                            i_in,
    ppoe_out_if.source                         o_out
);

    ppoe_pkg::t_cfg r_cfg;
    ppoe_pkg::t_cmd front_cmd;
    ppoe_pkg::t_cmd fifo_cmd;
    logic           push;
    logic           full;
    logic           pop;
    logic           cmd_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.output_enable     <= ppoe_pkg::RST_OUTPUT_ENABLE;
            r_cfg.control_mask      <= ppoe_pkg::RST_CONTROL_MASK;
            r_cfg.hold_ticks        <= ppoe_pkg::RST_HOLD_TICKS;
            r_cfg.ack_timeout_ticks <= ppoe_pkg::RST_ACK_TIMEOUT_TICKS;
            r_cfg.high_water        <= ppoe_pkg::RST_HIGH_WATER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppoe_pkg::CFG_OUTPUT_ENABLE: begin
                    r_cfg.output_enable <= i_cfg_data[0];
                end
                ppoe_pkg::CFG_CONTROL_MASK: begin
                    r_cfg.control_mask <= i_cfg_data[ppoe_pkg::LINES_W-1:0];
                end
                ppoe_pkg::CFG_HOLD_TICKS: begin
                    r_cfg.hold_ticks <= i_cfg_data[ppoe_pkg::HOLD_W-1:0];
                end
                ppoe_pkg::CFG_ACK_TIMEOUT_TICKS: begin
                    r_cfg.ack_timeout_ticks <= i_cfg_data[ppoe_pkg::TIMER_W-1:0];
                end
                ppoe_pkg::CFG_HIGH_WATER: begin
                    r_cfg.high_water <= i_cfg_data[ppoe_pkg::LEVEL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    ppoe_front u_front (
        .i_cfg  (r_cfg),
        .i_in   (i_in),
        .i_full (full),
        .o_push (push),
        .o_cmd  (front_cmd)
    );

    ppoe_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (fifo_cmd)
    );

    ppoe_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (fifo_cmd),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule

[rtl/ppoe_front.sv]
// front end: accepts input transactions and classifies them into commands
module ppoe_front (
    input  ppoe_pkg::t_cfg  i_cfg,
    ppoe_in_if.sink         i_in,
    input  logic            i_full,
    output logic            o_push,
    output ppoe_pkg::t_cmd  o_cmd
);

    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    always_comb begin
        o_cmd.req       = ppoe_pkg::t_req'(i_in.req_type);
        o_cmd.data_byte = i_in.data_byte;
        o_cmd.fault     = ppoe_pkg::line_fault(i_in.status_lines, i_cfg.control_mask);
    end

endmodule

[rtl/ppoe_cmd_fifo.sv]
// short command queue between front end and back end
module ppoe_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppoe_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output ppoe_pkg::t_cmd  o_cmd
);

    localparam int PtrW = (ppoe_pkg::CMD_DEPTH > 1) ? $clog2(ppoe_pkg::CMD_DEPTH) : 1;
    localparam int CntW = $clog2(ppoe_pkg::CMD_DEPTH + 1);

    ppoe_pkg::t_cmd  r_mem [ppoe_pkg::CMD_DEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;
    logic [PtrW-1:0] n_wr;
    logic [PtrW-1:0] n_rd;
    logic [CntW-1:0] n_cnt;

    assign o_full  = (r_cnt == CntW'(ppoe_pkg::CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(ppoe_pkg::CMD_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(ppoe_pkg::CMD_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

[rtl/ppoe_back.sv]
// back end: byte queue, send/hold/ack timer engine and result register
module ppoe_back #(
    parameter int QUEUE_DEPTH = ppoe_pkg::QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppoe_pkg::t_cfg  i_cfg,
    input  logic            i_cmd_valid,
    input  ppoe_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    ppoe_out_if.source      o_out
);

    localparam int PtrW  = $clog2(QUEUE_DEPTH);
    localparam int FillW = $clog2(QUEUE_DEPTH + 1);
    localparam int CmpW  = (FillW > ppoe_pkg::LEVEL_W) ? FillW : ppoe_pkg::LEVEL_W;

    logic [ppoe_pkg::DATA_W-1:0]  r_queue [QUEUE_DEPTH];
    logic [ppoe_pkg::DATA_W-1:0]  r_head_byte;

    logic                         r_pending, n_pending;
    logic                         r_hold, n_hold;
    logic                         r_err, n_err;
    logic [ppoe_pkg::DATA_W-1:0]  r_cur, n_cur;
    logic [ppoe_pkg::DATA_W-1:0]  r_latch, n_latch;
    logic [PtrW-1:0]              r_head, n_head;
    logic [PtrW-1:0]              r_tail, n_tail;
    logic [FillW-1:0]             r_fill, n_fill;
    logic [ppoe_pkg::TIMER_W-1:0] r_timer, n_timer;
    ppoe_pkg::t_mode              r_mode, n_mode;
    logic                         r_out_valid, n_out_valid;
    ppoe_pkg::t_result            r_out, n_out;

    logic                         advance;
    logic                         do_drive;
    logic                         do_enq;
    logic                         do_deq;
    logic                         strobe;
    logic [ppoe_pkg::DATA_W-1:0]  drive_byte;
    ppoe_pkg::t_wstat             wstat;
    logic                         over_water;
    logic                         queue_full;

    assign advance = i_cmd_valid && (!r_out_valid || o_out.ready);
    assign o_pop   = advance;

    assign over_water = CmpW'(r_fill) > CmpW'(i_cfg.high_water);
    assign queue_full = (r_fill == FillW'(QUEUE_DEPTH));

    // command execution
    always_comb begin
        n_pending  = r_pending;
        n_hold     = r_hold;
        n_err      = r_err;
        n_cur      = r_cur;
        n_latch    = r_latch;
        n_timer    = r_timer;
        n_mode     = r_mode;
        do_drive   = 1'b0;
        do_enq     = 1'b0;
        do_deq     = 1'b0;
        strobe     = 1'b0;
        drive_byte = r_cur;
        wstat      = ppoe_pkg::WS_OK;
        if (advance) begin
            unique case (i_cmd.req)
                ppoe_pkg::REQ_WRITE: begin
                    priority if (!i_cfg.output_enable) begin
                        wstat = ppoe_pkg::WS_NOT_EN;
                    end else if (r_err) begin
                        n_err = 1'b0;
                        wstat = ppoe_pkg::WS_ERROR;
                    end else if (over_water || queue_full) begin
                        wstat = ppoe_pkg::WS_FULL;
                    end else if (!r_pending) begin
                        do_drive   = 1'b1;
                        drive_byte = i_cmd.data_byte;
                    end else begin
                        do_enq = 1'b1;
                    end
                end
                ppoe_pkg::REQ_ACK: begin
                    if (r_pending) begin
                        n_mode  = ppoe_pkg::MODE_IDLE;
                        n_timer = '0;
                        if (r_fill != '0) begin
                            do_deq     = 1'b1;
                            do_drive   = 1'b1;
                            drive_byte = r_head_byte;
                        end else begin
                            n_pending = 1'b0;
                            n_hold    = 1'b0;
                        end
                    end
                end
                ppoe_pkg::REQ_TICK: begin
                    if (r_mode != ppoe_pkg::MODE_IDLE) begin
                        if (r_timer <= ppoe_pkg::TIMER_W'(1)) begin
                            n_mode  = ppoe_pkg::MODE_IDLE;
                            n_timer = '0;
                            if (r_mode == ppoe_pkg::MODE_ACK && !i_cmd.fault) begin
                                n_err = 1'b1;
                            end
                            do_drive = 1'b1;
                        end else begin
                            n_timer = r_timer - 1'b1;
                        end
                    end
                end
                ppoe_pkg::REQ_NONE: begin
                end
            endcase
        end
        if (do_drive) begin
            n_cur     = drive_byte;
            n_pending = 1'b1;
            if (i_cmd.fault) begin
                n_hold  = 1'b1;
                n_mode  = ppoe_pkg::MODE_HOLD;
                n_timer = ppoe_pkg::TIMER_W'(i_cfg.hold_ticks);
            end else begin
                n_hold  = 1'b0;
                n_latch = drive_byte;
                strobe  = 1'b1;
                n_mode  = ppoe_pkg::MODE_ACK;
                n_timer = i_cfg.ack_timeout_ticks;
            end
        end
    end

    // queue pointers and level
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_fill = r_fill;
        if (do_enq) begin
            n_tail = (r_tail == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            n_fill = r_fill + 1'b1;
        end else if (do_deq) begin
            n_head = (r_head == PtrW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            n_fill = r_fill - 1'b1;
        end
    end

    // result assembly and output register
    always_comb begin
        n_out.data_out     = n_latch;
        n_out.data_strobe  = strobe;
        n_out.send_pending = n_pending;
        n_out.stopped      = n_hold;
        n_out.error_flag   = n_err;
        n_out.queue_level  = ppoe_pkg::LEVEL_W'(n_fill);
        n_out.writable     = n_err || (CmpW'(n_fill) <= CmpW'(i_cfg.high_water));
        n_out.write_status = wstat;
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_hold      <= 1'b0;
            r_err       <= 1'b0;
            r_cur       <= '0;
            r_latch     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_fill      <= '0;
            r_timer     <= '0;
            r_mode      <= ppoe_pkg::MODE_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_pending   <= n_pending;
            r_hold      <= n_hold;
            r_err       <= n_err;
            r_cur       <= n_cur;
            r_latch     <= n_latch;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_fill      <= n_fill;
            r_timer     <= n_timer;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // byte queue with the head byte read ahead, write bypass into an empty slot
    always_ff @(posedge i_clk) begin
        if (do_enq) begin
            r_queue[r_tail] <= i_cmd.data_byte;
        end
        if (do_enq && (r_tail == n_head)) begin
            r_head_byte <= i_cmd.data_byte;
        end else begin
            r_head_byte <= r_queue[n_head];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.data_out     = r_out.data_out;
    assign o_out.data_strobe  = r_out.data_strobe;
    assign o_out.send_pending = r_out.send_pending;
    assign o_out.stopped      = r_out.stopped;
    assign o_out.error_flag   = r_out.error_flag;
    assign o_out.queue_level  = r_out.queue_level;
    assign o_out.writable     = r_out.writable;
    assign o_out.write_status = r_out.write_status;

endmodule
